@@ design/ordered_queue_with_extract_min_defines.svh @@
// ----------------------------------------------------------------------------
// Ordered queue assertion macros
// Shared concurrent assertion forms for the ordered queue design.
// ----------------------------------------------------------------------------
`ifndef ORDERED_QUEUE_WITH_EXTRACT_MIN_DEFINES_SVH
`define ORDERED_QUEUE_WITH_EXTRACT_MIN_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define OQM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define OQM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/oqm_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered queue package
// Field widths, request and status codes, controller states and cell control.
// ----------------------------------------------------------------------------
package oqm_pkg;

    localparam int REQ_W   = 2;
    localparam int KEY_W   = 16;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND  = 2'd0,
        REQ_POP_OLD = 2'd1,
        REQ_POP_MIN = 2'd2,
        REQ_QUERY   = 2'd3
    } t_req_type;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2,
        S_RESP  = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

@@ design/oqm_if.sv @@
// ----------------------------------------------------------------------------
// Ordered queue channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface oqm_req_if;
    logic                             valid;
    logic                             ready;
    logic [oqm_pkg::REQ_W-1:0]        req_type;
    logic [oqm_pkg::KEY_W-1:0]        entry_key;
    logic signed [oqm_pkg::VAL_W-1:0] entry_value;

    modport source (output valid, req_type, entry_key, entry_value, input ready);
    modport sink   (input valid, req_type, entry_key, entry_value, output ready);
endinterface

interface oqm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [oqm_pkg::ST_W-1:0]         status;
    logic [oqm_pkg::KEY_W-1:0]        out_key;
    logic signed [oqm_pkg::VAL_W-1:0] out_value;
    logic                             found;
    logic [oqm_pkg::COUNT_W-1:0]      entry_count;

    modport source (output valid, status, out_key, out_value, found, entry_count,
                    input ready);
    modport sink   (input valid, status, out_key, out_value, found, entry_count,
                    output ready);
endinterface

@@ design/ordered_queue_with_extract_min.sv @@
// Flow: append goes straight to the response state, pop oldest shifts the chain first,
//   pop smallest scans then shifts, key query scans (one cell per cycle, one read port).
// One request in flight; the next is taken once the response is registered, which
//   waits while the previous reply is still held in the response register.
// Reset: held count, controller state and response valid clear; cell contents
//   stay undefined until written.
// ----------------------------------------------------------------------------
// Ordered queue with extract-min
// Arrival-ordered chain of entry cells with a scanning controller.
// ----------------------------------------------------------------------------
`include "ordered_queue_with_extract_min_defines.svh"

module ordered_queue_with_extract_min #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_WIDTH   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oqm_req_if.sink   i_req,
    oqm_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SKW   = (KEY_WIDTH < oqm_pkg::KEY_W) ? KEY_WIDTH : oqm_pkg::KEY_W;
    localparam int VW    = oqm_pkg::VAL_W;

    // chain
    oqm_pkg::t_cell_ctl      w_ctl   [QUEUE_DEPTH];
    logic [SKW-1:0]          w_key   [QUEUE_DEPTH];
    logic signed [VW-1:0]    w_value [QUEUE_DEPTH];

    // control state
    oqm_pkg::t_state         r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_o_valid, n_o_valid;

    // working payload
    oqm_pkg::t_req_type      r_req, n_req;
    logic [SKW-1:0]          r_key, n_key;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [IDX_W-1:0]        r_pick, n_pick;
    logic signed [VW-1:0]    r_best, n_best;
    oqm_pkg::t_status        r_status, n_status;
    logic [SKW-1:0]          r_rk, n_rk;
    logic signed [VW-1:0]    r_rv, n_rv;
    logic                    r_found, n_found;

    // response register
    oqm_pkg::t_status            r_o_status, n_o_status;
    logic [oqm_pkg::KEY_W-1:0]   r_o_key, n_o_key;
    logic signed [VW-1:0]        r_o_value, n_o_value;
    logic                        r_o_found, n_o_found;
    logic [oqm_pkg::COUNT_W-1:0] r_o_count, n_o_count;

    logic                    w_accept;
    logic [SKW-1:0]          w_in_key;
    logic [IDX_W-1:0]        w_rd_idx;
    logic [SKW-1:0]          w_rd_key;
    logic signed [VW-1:0]    w_rd_value;
    logic                    w_last;
    logic                    w_load_en;
    logic                    w_shift_en;
    logic [SKW+15:0]         w_rk_ext;
    logic [CNT_W+4:0]        w_cnt_ext;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g < QUEUE_DEPTH - 1) begin : g_mid
                oqm_cell #(.SKW(SKW)) u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (w_ctl[g]),
                    .i_load_key   (w_in_key),
                    .i_load_value (i_req.entry_value),
                    .i_nxt_key    (w_key[g+1]),
                    .i_nxt_value  (w_value[g+1]),
                    .o_key        (w_key[g]),
                    .o_value      (w_value[g])
                );
            end else begin : g_end
                oqm_cell #(.SKW(SKW)) u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (w_ctl[g]),
                    .i_load_key   (w_in_key),
                    .i_load_value (i_req.entry_value),
                    .i_nxt_key    (w_key[g]),
                    .i_nxt_value  (w_value[g]),
                    .o_key        (w_key[g]),
                    .o_value      (w_value[g])
                );
            end
        end
    endgenerate

    assign i_req.ready = (r_state == oqm_pkg::S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_key    = i_req.entry_key[SKW-1:0];

    assign w_rd_idx    = (r_state == oqm_pkg::S_SHIFT) ? r_pick : r_idx;
    assign w_rd_key    = w_key[w_rd_idx];
    assign w_rd_value  = w_value[w_rd_idx];
    assign w_last      = (CNT_W'(r_idx) == r_count - CNT_W'(1));

    assign w_load_en   = w_accept && (i_req.req_type == oqm_pkg::REQ_APPEND)
                         && (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_shift_en  = (r_state == oqm_pkg::S_SHIFT);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_ctl[i].load  = w_load_en && (CNT_W'(i) == r_count);
            // close the gap: every cell at or after the removed one takes its neighbor
            w_ctl[i].shift = w_shift_en && (IDX_W'(i) >= r_pick);
        end
    end

    assign w_rk_ext  = {16'd0, r_rk};
    assign w_cnt_ext = {5'd0, r_count};

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_req      = r_req;
        n_key      = r_key;
        n_idx      = r_idx;
        n_pick     = r_pick;
        n_best     = r_best;
        n_status   = r_status;
        n_rk       = r_rk;
        n_rv       = r_rv;
        n_found    = r_found;
        n_o_status = r_o_status;
        n_o_key    = r_o_key;
        n_o_value  = r_o_value;
        n_o_found  = r_o_found;
        n_o_count  = r_o_count;

        case (r_state)
            oqm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_req    = oqm_pkg::t_req_type'(i_req.req_type);
                    n_key    = w_in_key;
                    n_status = oqm_pkg::ST_OK;
                    n_rk     = '0;
                    n_rv     = '0;
                    n_found  = 1'b0;
                    n_pick   = '0;
                    n_idx    = '0;
                    n_best   = w_value[0];
                    n_state  = oqm_pkg::S_RESP;
                    case (oqm_pkg::t_req_type'(i_req.req_type))
                        oqm_pkg::REQ_APPEND: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_status = oqm_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        oqm_pkg::REQ_POP_OLD: begin
                            if (r_count == '0) begin
                                n_status = oqm_pkg::ST_EMPTY;
                            end else begin
                                n_state = oqm_pkg::S_SHIFT;
                            end
                        end
                        oqm_pkg::REQ_POP_MIN: begin
                            n_idx = IDX_W'(1);
                            if (r_count == '0) begin
                                n_status = oqm_pkg::ST_EMPTY;
                            end else if (r_count == CNT_W'(1)) begin
                                n_state = oqm_pkg::S_SHIFT;
                            end else begin
                                n_state = oqm_pkg::S_SCAN;
                            end
                        end
                        oqm_pkg::REQ_QUERY: begin
                            if (r_count != '0) begin
                                n_state = oqm_pkg::S_SCAN;
                            end
                        end
                        default: begin
                            n_state = oqm_pkg::S_RESP;
                        end
                    endcase
                end
            end
            oqm_pkg::S_SCAN: begin
                if (r_req == oqm_pkg::REQ_QUERY) begin
                    if (w_rd_key == r_key) begin
                        n_found = 1'b1;
                        n_state = oqm_pkg::S_RESP;
                    end else if (w_last) begin
                        n_state = oqm_pkg::S_RESP;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    // strict compare keeps the earliest entry on ties
                    if (w_rd_value < r_best) begin
                        n_pick = r_idx;
                        n_best = w_rd_value;
                    end
                    if (w_last) begin
                        n_state = oqm_pkg::S_SHIFT;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            oqm_pkg::S_SHIFT: begin
                n_rk    = w_rd_key;
                n_rv    = w_rd_value;
                n_count = r_count - CNT_W'(1);
                n_state = oqm_pkg::S_RESP;
            end
            oqm_pkg::S_RESP: begin
                // hold until the response register is free
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_key    = w_rk_ext[15:0];
                    n_o_value  = r_rv;
                    n_o_found  = r_found;
                    n_o_count  = w_cnt_ext[4:0];
                    n_state    = oqm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oqm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= oqm_pkg::S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_pick     <= n_pick;
        r_best     <= n_best;
        r_status   <= n_status;
        r_rk       <= n_rk;
        r_rv       <= n_rv;
        r_found    <= n_found;
        r_o_status <= n_o_status;
        r_o_key    <= n_o_key;
        r_o_value  <= n_o_value;
        r_o_found  <= n_o_found;
        r_o_count  <= n_o_count;
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.out_key     = r_o_key;
    assign o_rsp.out_value   = r_o_value;
    assign o_rsp.found       = r_o_found;
    assign o_rsp.entry_count = r_o_count;

    `OQM_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH),
        "held count exceeds queue depth")
    `OQM_ASSERT_NOW(a_scan_in_range, r_state == oqm_pkg::S_SCAN,
        CNT_W'(r_idx) < r_count, "scan index past held entries")
    `OQM_ASSERT_NEXT(a_append_grows, w_load_en,
        r_count == $past(r_count) + CNT_W'(1), "append did not grow the count")
    `OQM_ASSERT_NOW(a_empty_zero, o_rsp.valid && o_rsp.status == oqm_pkg::ST_EMPTY,
        o_rsp.out_key == '0 && o_rsp.out_value == '0 && o_rsp.entry_count == '0,
        "empty pop response carries data")

endmodule

@@ design/oqm_cell.sv @@
// ----------------------------------------------------------------------------
// Ordered queue cell
// One queue slot: loads an appended entry or takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module oqm_cell #(
    parameter int SKW = 16
) (
    input  logic                             i_clk,
    input  oqm_pkg::t_cell_ctl               i_ctl,
    input  logic [SKW-1:0]                   i_load_key,
    input  logic signed [oqm_pkg::VAL_W-1:0] i_load_value,
    input  logic [SKW-1:0]                   i_nxt_key,
    input  logic signed [oqm_pkg::VAL_W-1:0] i_nxt_value,
    output logic [SKW-1:0]                   o_key,
    output logic signed [oqm_pkg::VAL_W-1:0] o_value
);

    logic [SKW-1:0]                   r_key;
    logic signed [oqm_pkg::VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key   <= i_load_key;
            r_value <= i_load_value;
        end else if (i_ctl.shift) begin
            r_key   <= i_nxt_key;
            r_value <= i_nxt_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

@@ tb/oqm_reply_checker.sv @@
// ----------------------------------------------------------------------------
// Ordered queue reply checker
// Watches the request and reply channels, keeps a shadow of the queue
// contents, and compares every reply word field by field with its prediction.
// ----------------------------------------------------------------------------
module oqm_reply_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    oqm_req_if   req_ch,
    oqm_rsp_if   rsp_ch,
    output int   o_mismatches,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_W   = oqm_pkg::KEY_W;
    localparam int VAL_W   = oqm_pkg::VAL_W;
    localparam int COUNT_W = oqm_pkg::COUNT_W;

    typedef struct {
        oqm_pkg::t_status          status;
        logic [KEY_W-1:0]          key;
        logic signed [VAL_W-1:0]   value;
        logic                      found;
        logic [COUNT_W-1:0]        count;
    } t_reply;

    // Shadow of the queue in arrival order
    logic [KEY_W-1:0]        held_keys   [QUEUE_DEPTH];
    logic signed [VAL_W-1:0] held_values [QUEUE_DEPTH];
    int                      held = 0;
    t_reply                  replies_due [$];
    int                      mismatches = 0;

    function automatic t_reply apply_request(oqm_pkg::t_req_type kind,
                                             logic [KEY_W-1:0] key,
                                             logic signed [VAL_W-1:0] value);
        t_reply r;
        int     pick;
        int     i;
        r.status = oqm_pkg::ST_OK;
        r.key    = '0;
        r.value  = '0;
        r.found  = 1'b0;
        pick     = 0;
        case (kind)
            oqm_pkg::REQ_APPEND: begin
                if (held >= QUEUE_DEPTH) begin
                    r.status = oqm_pkg::ST_FULL;
                end else begin
                    held_keys[held]   = key;
                    held_values[held] = value;
                    held++;
                end
            end
            oqm_pkg::REQ_POP_OLD, oqm_pkg::REQ_POP_MIN: begin
                if (held == 0) begin
                    r.status = oqm_pkg::ST_EMPTY;
                end else begin
                    // strict less-than keeps the earliest of equal values
                    if (kind == oqm_pkg::REQ_POP_MIN) begin
                        for (i = 1; i < held; i++) begin
                            if (held_values[i] < held_values[pick]) pick = i;
                        end
                    end
                    r.key   = held_keys[pick];
                    r.value = held_values[pick];
                    // close the gap, keep arrival order
                    for (i = pick; i < held - 1; i++) begin
                        held_keys[i]   = held_keys[i + 1];
                        held_values[i] = held_values[i + 1];
                    end
                    held--;
                end
            end
            oqm_pkg::REQ_QUERY: begin
                for (i = 0; i < held; i++) begin
                    if (held_keys[i] == key) r.found = 1'b1;
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(held);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (i_rst_n) begin
            // push before pop so a word leaving at the same edge still finds its entry
            if (req_ch.valid && req_ch.ready) begin
                replies_due.push_back(apply_request(oqm_pkg::t_req_type'(req_ch.req_type),
                                                    req_ch.entry_key, req_ch.entry_value));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (replies_due.size() == 0) begin
                    $error("reply word with no request outstanding");
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", want.status, rsp_ch.status);
                    check_field("out_key", want.key, rsp_ch.out_key);
                    check_field("out_value", want.value, rsp_ch.out_value);
                    check_field("found", want.found, rsp_ch.found);
                    check_field("entry_count", want.count, rsp_ch.entry_count);
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= replies_due.size();
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Ordered queue testbench top
// Drives directed and random request words with random gaps on both channels,
// including two long reply stalls, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_WORDS = 1800;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int KEY_W        = oqm_pkg::KEY_W;
    localparam int VAL_W        = oqm_pkg::VAL_W;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    int                  mismatches;
    int                  outstanding;
    int                  cyc = 0;
    int                  words_sent = 0;
    logic [KEY_W-1:0]    recent_keys [8];
    int                  recent_wr = 0;

    oqm_req_if req_ch ();
    oqm_rsp_if rsp_ch ();

    ordered_queue_with_extract_min #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    oqm_reply_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_reply_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req_ch        (req_ch),
        .rsp_ch        (rsp_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic oqm_pkg::t_req_type rand_kind(int append_pct);
        if ($urandom_range(0, 99) < append_pct) return oqm_pkg::REQ_APPEND;
        case ($urandom_range(0, 2))
            0:       return oqm_pkg::REQ_POP_OLD;
            1:       return oqm_pkg::REQ_POP_MIN;
            default: return oqm_pkg::REQ_QUERY;
        endcase
    endfunction

    // favor keys that are likely held so queries hit
    function automatic logic [KEY_W-1:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return KEY_W'($urandom_range(0, 7));
        if (r < 7) return recent_keys[$urandom_range(0, 7)];
        return KEY_W'($urandom_range(0, 65535));
    endfunction

    // small values make ties on pop smallest common
    function automatic logic signed [VAL_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7) return VAL_W'($urandom_range(0, 8)) - 4;
        if (r < 9) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_word(oqm_pkg::t_req_type kind, logic [KEY_W-1:0] key,
                             logic signed [VAL_W-1:0] value);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.entry_key   <= key;
        req_ch.entry_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        if (kind == oqm_pkg::REQ_APPEND) begin
            recent_keys[recent_wr] = key;
            recent_wr = (recent_wr + 1) % 8;
        end
        words_sent++;
        // hold valid through back-to-back stretches
        gap = (words_sent % 300 < 50) ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin : reply_ready
        int gap;
        int holds_done;
        holds_done = 0;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            // long stall so the block backs up and stops taking requests
            if (holds_done < 2 && cyc >= (holds_done == 0 ? 3000 : 15000)) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int n;
        int len;
        int append_pct;
        int i;
        for (i = 0; i < 8; i++) recent_keys[i] = '0;
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= oqm_pkg::REQ_APPEND;
        req_ch.entry_key   <= '0;
        req_ch.entry_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue
        send_word(oqm_pkg::REQ_POP_OLD, '0, '0);
        send_word(oqm_pkg::REQ_POP_MIN, '0, '0);
        send_word(oqm_pkg::REQ_QUERY, '0, '0);
        // extremes, tie on the smallest value
        send_word(oqm_pkg::REQ_APPEND, 16'hFFFF, 32'sh7FFF_FFFF);
        send_word(oqm_pkg::REQ_APPEND, 16'h0000, 32'sh8000_0000);
        send_word(oqm_pkg::REQ_APPEND, 16'h0005, 32'sh8000_0000);
        send_word(oqm_pkg::REQ_QUERY, 16'hFFFF, '0);
        send_word(oqm_pkg::REQ_QUERY, 16'hABCD, '0);
        send_word(oqm_pkg::REQ_POP_MIN, '0, '0);
        send_word(oqm_pkg::REQ_POP_OLD, '0, '0);
        send_word(oqm_pkg::REQ_POP_OLD, '0, '0);
        // fill up, smallest value twice in the middle
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            send_word(oqm_pkg::REQ_APPEND, KEY_W'(16'h0100 + i),
                      (i == 7 || i == 12) ? -100 : i);
        end
        send_word(oqm_pkg::REQ_APPEND, 16'h0200, 32'sd1);
        send_word(oqm_pkg::REQ_QUERY, 16'h010C, '0);
        send_word(oqm_pkg::REQ_POP_MIN, '0, '0);

        // random phases: filling, draining, balanced
        n = 0;
        while (n < RANDOM_WORDS) begin
            case ($urandom_range(0, 2))
                0:       append_pct = 70;
                1:       append_pct = 20;
                default: append_pct = 45;
            endcase
            len = $urandom_range(20, 80);
            repeat (len) begin
                send_word(rand_kind(append_pct), rand_key(), rand_value());
                n++;
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/oqm_pkg.sv
design/oqm_if.sv
design/oqm_cell.sv
design/ordered_queue_with_extract_min.sv
tb/oqm_reply_checker.sv
tb/tb_top.sv
